// File: rtl/dbp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dbp_pkg: shared types and constants for depth pixel back-projection
// operation codes, register indexes, controller states and handshake structs
// ----------------------------------------------------------------------------
package dbp_pkg;

    localparam int unsigned MAX_AREAS_DEF       = 8;
    localparam int unsigned DEPTH_FRAC_BITS_DEF = 10;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 24;

    localparam logic [1:0] OP_PIXEL      = 2'd0;
    localparam logic [1:0] OP_AREA_WRITE = 2'd1;
    localparam logic [1:0] OP_AREA_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RECIP_FOCAL_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RECIP_FOCAL_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 3'd4;

    localparam logic [12:0] FRAME_WIDTH_RST = 13'd640;
    localparam logic [12:0] FRAME_WIDTH_MAX = 13'd4096;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic mul1;
        logic mul2;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic produce;
        logic out_free;
    } t_dp_sts;

endpackage
`default_nettype wire

// File: rtl/dbp_mask.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dbp_mask: masked rectangle table
// holds the rectangle slots and flags a pixel that falls inside any valid one
// ----------------------------------------------------------------------------
module dbp_mask
    import dbp_pkg::*;
#(
    parameter int unsigned MAX_AREAS = MAX_AREAS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_wr,
    input  wire logic        i_clr,
    input  wire logic [2:0]  i_slot,
    input  wire logic [11:0] i_left,
    input  wire logic [11:0] i_top,
    input  wire logic [12:0] i_width,
    input  wire logic [12:0] i_height,
    input  wire logic [11:0] i_col,
    input  wire logic [11:0] i_row,
    output logic             o_masked
);

    logic [11:0]          r_left   [MAX_AREAS];
    logic [11:0]          r_top    [MAX_AREAS];
    logic [12:0]          r_width  [MAX_AREAS];
    logic [12:0]          r_height [MAX_AREAS];
    logic [MAX_AREAS-1:0] r_valid;
    logic [MAX_AREAS-1:0] w_hit;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_AREAS; k++) begin
            if (i_wr && ({4'd0, i_slot} == 7'(k))) begin
                r_left[k]   <= i_left;
                r_top[k]    <= i_top;
                r_width[k]  <= i_width;
                r_height[k] <= i_height;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_clr) begin
            r_valid <= '0;
        end else begin
            for (int k = 0; k < MAX_AREAS; k++) begin
                if (i_wr && ({4'd0, i_slot} == 7'(k))) begin
                    r_valid[k] <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < MAX_AREAS; k++) begin
            w_hit[k] = r_valid[k]
                && (i_col >= r_left[k])
                && ({2'b00, i_col} < ({2'b00, r_left[k]} + {1'b0, r_width[k]}))
                && (i_row >= r_top[k])
                && ({2'b00, i_row} < ({2'b00, r_top[k]} + {1'b0, r_height[k]}));
        end
        o_masked = |w_hit;
    end

endmodule
`default_nettype wire

// File: rtl/dbp_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dbp_ctrl: sequencing state machine
// takes an item; for one that yields a point, steps the two multiply stages and hands the point to output
// ----------------------------------------------------------------------------
module dbp_ctrl
    import dbp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire t_dp_sts i_sts,
    output logic         o_in_stall,
    output t_dp_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.produce) begin
                        n_state = S_MUL1;
                    end
                end
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/dbp_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dbp_datapath: counters, registers and projection arithmetic
// offset from principal point, two multiply stages, rounding and saturation
// ----------------------------------------------------------------------------
module dbp_datapath
    import dbp_pkg::*;
#(
    parameter int unsigned MAX_AREAS       = MAX_AREAS_DEF,
    parameter int unsigned DEPTH_FRAC_BITS = DEPTH_FRAC_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_sts                    o_sts,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [1:0]            i_operation,
    input  wire logic                  i_frame_start,
    input  wire logic [15:0]           i_depth,
    input  wire logic [7:0]            i_in_red,
    input  wire logic [7:0]            i_in_green,
    input  wire logic [7:0]            i_in_blue,
    input  wire logic [2:0]            i_area_slot,
    input  wire logic [11:0]           i_area_left,
    input  wire logic [11:0]           i_area_top,
    input  wire logic [12:0]           i_area_width,
    input  wire logic [12:0]           i_area_height,
    input  wire logic                  i_out_stall,
    output logic                       o_out_valid,
    output logic signed [23:0]         o_point_x,
    output logic signed [23:0]         o_point_y,
    output logic [15:0]                o_point_z,
    output logic [7:0]                 o_out_red,
    output logic [7:0]                 o_out_green,
    output logic [7:0]                 o_out_blue
);

    localparam logic [31:0] DEPTH_MIN = 32'(((1 << DEPTH_FRAC_BITS) + 99) / 100);
    localparam logic [31:0] DEPTH_MAX = 32'(10 << DEPTH_FRAC_BITS);
    localparam logic [56:0] ROUND_HALF = 57'd1 << 27;

    function automatic logic [23:0] round_sat(input logic [55:0] prod, input logic neg);
        logic [56:0] s;
        logic [28:0] q;
        logic [28:0] nq;
        s = {1'b0, prod} + ROUND_HALF;
        q = s[56:28];
        if (neg) begin
            if (q > 29'd8388608) begin
                q = 29'd8388608;
            end
            nq = 29'd0 - q;
            return nq[23:0];
        end
        if (q > 29'd8388607) begin
            return 24'h7FFFFF;
        end
        return q[23:0];
    endfunction

    logic [15:0] r_center_x;
    logic [15:0] r_center_y;
    logic [23:0] r_recip_x;
    logic [23:0] r_recip_y;
    logic [12:0] r_frame_width;
    logic [11:0] r_col;
    logic [11:0] r_row;

    logic        r_neg_x;
    logic        r_neg_y;
    logic [15:0] r_mag_x;
    logic [15:0] r_mag_y;
    logic [15:0] r_depth;
    logic [7:0]  r_red;
    logic [7:0]  r_green;
    logic [7:0]  r_blue;
    logic [31:0] r_pd_x;
    logic [31:0] r_pd_y;
    logic [55:0] r_prod_x;
    logic [55:0] r_prod_y;

    logic               r_out_valid;
    logic signed [23:0] r_px;
    logic signed [23:0] r_py;
    logic [15:0]        r_pz;
    logic [7:0]         r_ored;
    logic [7:0]         r_ogreen;
    logic [7:0]         r_oblue;

    logic        w_is_pixel;
    logic [11:0] w_col;
    logic [11:0] w_row;
    logic        w_masked;
    logic        w_depth_ok;
    logic [16:0] w_diff_x;
    logic [16:0] w_diff_y;
    logic [16:0] w_ndiff_x;
    logic [16:0] w_ndiff_y;
    logic [12:0] w_fw;
    logic [12:0] w_col_inc;

    dbp_mask #(
        .MAX_AREAS (MAX_AREAS)
    ) u_mask (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (i_cmd.accept && (i_operation == OP_AREA_WRITE)),
        .i_clr    (i_cmd.accept && (i_operation == OP_AREA_CLEAR)),
        .i_slot   (i_area_slot),
        .i_left   (i_area_left),
        .i_top    (i_area_top),
        .i_width  (i_area_width),
        .i_height (i_area_height),
        .i_col    (w_col),
        .i_row    (w_row),
        .o_masked (w_masked)
    );

    always_comb begin
        w_is_pixel = (i_operation == OP_PIXEL);
        w_col      = i_frame_start ? 12'd0 : r_col;
        w_row      = i_frame_start ? 12'd0 : r_row;
        w_depth_ok = ({16'd0, i_depth} >= DEPTH_MIN) && ({16'd0, i_depth} <= DEPTH_MAX);
        w_diff_x   = {1'b0, w_col, 4'd0} - {1'b0, r_center_x};
        w_diff_y   = {1'b0, w_row, 4'd0} - {1'b0, r_center_y};
        w_ndiff_x  = 17'd0 - w_diff_x;
        w_ndiff_y  = 17'd0 - w_diff_y;
        if ((r_frame_width == 13'd0) || (r_frame_width > FRAME_WIDTH_MAX)) begin
            w_fw = FRAME_WIDTH_MAX;
        end else begin
            w_fw = r_frame_width;
        end
        w_col_inc = {1'b0, w_col} + 13'd1;

        o_sts.produce  = w_is_pixel && !w_masked && w_depth_ok;
        o_sts.out_free = !r_out_valid || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x    <= '0;
            r_center_y    <= '0;
            r_recip_x     <= '0;
            r_recip_y     <= '0;
            r_frame_width <= FRAME_WIDTH_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CENTER_X:      r_center_x    <= i_cfg_data[15:0];
                CFG_CENTER_Y:      r_center_y    <= i_cfg_data[15:0];
                CFG_RECIP_FOCAL_X: r_recip_x     <= i_cfg_data;
                CFG_RECIP_FOCAL_Y: r_recip_y     <= i_cfg_data;
                CFG_FRAME_WIDTH:   r_frame_width <= i_cfg_data[12:0];
                default: begin
                end
            endcase
        end
    end

    // raster counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.accept && w_is_pixel) begin
            if (w_col_inc >= w_fw) begin
                r_col <= '0;
                r_row <= w_row + 12'd1;
            end else begin
                r_col <= w_col_inc[11:0];
                r_row <= w_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_neg_x <= w_diff_x[16];
            r_neg_y <= w_diff_y[16];
            r_mag_x <= w_diff_x[16] ? w_ndiff_x[15:0] : w_diff_x[15:0];
            r_mag_y <= w_diff_y[16] ? w_ndiff_y[15:0] : w_diff_y[15:0];
            r_depth <= i_depth;
            r_red   <= i_in_red;
            r_green <= i_in_green;
            r_blue  <= i_in_blue;
        end
        if (i_cmd.mul1) begin
            r_pd_x <= r_mag_x * r_depth;
            r_pd_y <= r_mag_y * r_depth;
        end
        if (i_cmd.mul2) begin
            r_prod_x <= r_pd_x * r_recip_x;
            r_prod_y <= r_pd_y * r_recip_y;
        end
        if (i_cmd.load_out) begin
            r_px     <= signed'(round_sat(r_prod_x, r_neg_x));
            r_py     <= signed'(round_sat(r_prod_y, r_neg_y));
            r_pz     <= r_depth;
            r_ored   <= r_red;
            r_ogreen <= r_green;
            r_oblue  <= r_blue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_point_x   = r_px;
    assign o_point_y   = r_py;
    assign o_point_z   = r_pz;
    assign o_out_red   = r_ored;
    assign o_out_green = r_ogreen;
    assign o_out_blue  = r_oblue;

endmodule
`default_nettype wire

// File: rtl/depth_pixel_backprojection.sv
`default_nettype none
// ----------------------------------------------------------------------------
// depth_pixel_backprojection: RGB-D pixel to camera-frame point
// masks pixels by rectangle table and depth limits, projects through pinhole
//
//   channel   handshake                 payload
//   input     i_in_valid / o_in_stall   operation, frame_start, depth, color, area
//   output    o_out_valid / i_out_stall point_x/y/z, color
//   config    i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// a pixel that yields a point goes through accept, two multiply stages
// (offset times depth, then times reciprocal focal length), round and load
// a rejected pixel or a table operation is finished at accept, with no stall
// the last step waits while the output register holds an untaken point
// synchronous active-low reset; the rectangle table needs no clearing pass
// ----------------------------------------------------------------------------
module depth_pixel_backprojection
    import dbp_pkg::*;
#(
    parameter int unsigned MAX_AREAS       = MAX_AREAS_DEF,
    parameter int unsigned DEPTH_FRAC_BITS = DEPTH_FRAC_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [1:0]            i_operation,
    input  wire logic                  i_frame_start,
    input  wire logic [15:0]           i_depth,
    input  wire logic [7:0]            i_in_red,
    input  wire logic [7:0]            i_in_green,
    input  wire logic [7:0]            i_in_blue,
    input  wire logic [2:0]            i_area_slot,
    input  wire logic [11:0]           i_area_left,
    input  wire logic [11:0]           i_area_top,
    input  wire logic [12:0]           i_area_width,
    input  wire logic [12:0]           i_area_height,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic signed [23:0]         o_point_x,
    output logic signed [23:0]         o_point_y,
    output logic [15:0]                o_point_z,
    output logic [7:0]                 o_out_red,
    output logic [7:0]                 o_out_green,
    output logic [7:0]                 o_out_blue
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    assign o_cfg_ready = 1'b1;

    dbp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    dbp_datapath #(
        .MAX_AREAS       (MAX_AREAS),
        .DEPTH_FRAC_BITS (DEPTH_FRAC_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_operation   (i_operation),
        .i_frame_start (i_frame_start),
        .i_depth       (i_depth),
        .i_in_red      (i_in_red),
        .i_in_green    (i_in_green),
        .i_in_blue     (i_in_blue),
        .i_area_slot   (i_area_slot),
        .i_area_left   (i_area_left),
        .i_area_top    (i_area_top),
        .i_area_width  (i_area_width),
        .i_area_height (i_area_height),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_point_x     (o_point_x),
        .o_point_y     (o_point_y),
        .o_point_z     (o_point_z),
        .o_out_red     (o_out_red),
        .o_out_green   (o_out_green),
        .o_out_blue    (o_out_blue)
    );

`ifndef SYNTH
    a_busy_after_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.accept && w_sts.produce) |=> o_in_stall)
        else $error("input not stalled while a point is in flight");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> w_sts.out_free)
        else $error("output register overwritten before taken");

    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.load_out))
        else $error("output valid without a load");
`endif

endmodule
`default_nettype wire

// File: tb/sv/depth_pixel_backprojection_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// depth_pixel_backprojection_test: self-checking bench for the back-projector
// a queue of scan items feeds a bursty driver; every accepted item runs through
// a local pinhole predictor (scan counters, mask table, fixed-point projection)
// and the monitor checks each point against the oldest predicted one while the
// output side stalls in changing patterns; config is rewritten between phases
// ----------------------------------------------------------------------------
module depth_pixel_backprojection_test;
    import dbp_pkg::*;

    localparam logic [1:0]           OP_RESERVED   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO  = CFG_FRAME_WIDTH + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI  = '1;
    localparam int unsigned DEPTH_MIN   = ((1 << DEPTH_FRAC_BITS_DEF) + 99) / 100;
    localparam int unsigned DEPTH_MAX   = 10 << DEPTH_FRAC_BITS_DEF;
    localparam longint unsigned AXIS_POS_MAX = 64'd8388607;
    localparam longint unsigned AXIS_NEG_MAX = 64'd8388608;
    localparam int IDLE_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_LONG,
        STALL_HEAVY
    } t_stall_mode;

    typedef struct packed {
        logic [1:0]  operation;
        logic        frame_start;
        logic [15:0] depth;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [2:0]  slot;
        logic [11:0] left;
        logic [11:0] top;
        logic [12:0] width;
        logic [12:0] height;
    } t_scan_item;

    typedef struct packed {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic [15:0]        z;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
    } t_point;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  i_in_valid    = 1'b0;
    logic                  o_in_stall;
    logic [1:0]            i_operation   = OP_PIXEL;
    logic                  i_frame_start = 1'b0;
    logic [15:0]           i_depth       = '0;
    logic [7:0]            i_in_red      = '0;
    logic [7:0]            i_in_green    = '0;
    logic [7:0]            i_in_blue     = '0;
    logic [2:0]            i_area_slot   = '0;
    logic [11:0]           i_area_left   = '0;
    logic [11:0]           i_area_top    = '0;
    logic [12:0]           i_area_width  = '0;
    logic [12:0]           i_area_height = '0;
    logic                  o_out_valid;
    logic                  i_out_stall   = 1'b0;
    logic signed [23:0]    o_point_x;
    logic signed [23:0]    o_point_y;
    logic [15:0]           o_point_z;
    logic [7:0]            o_out_red;
    logic [7:0]            o_out_green;
    logic [7:0]            o_out_blue;

    // predictor state
    int unsigned scan_col;
    int unsigned scan_row;
    int unsigned mask_left   [MAX_AREAS_DEF];
    int unsigned mask_top    [MAX_AREAS_DEF];
    int unsigned mask_width  [MAX_AREAS_DEF];
    int unsigned mask_height [MAX_AREAS_DEF];
    bit          mask_live   [MAX_AREAS_DEF];
    int unsigned cfg_center_x;
    int unsigned cfg_center_y;
    int unsigned cfg_recip_x;
    int unsigned cfg_recip_y;
    int unsigned cfg_frame_width;

    t_scan_item  pending_items [$];
    t_point      expected_points [$];
    t_scan_item  cur_item;
    t_point      next_point;
    t_point      want;
    int          mismatches;
    int          burst_left;
    int          gap_left;
    int          stall_left;
    t_stall_mode stall_mode;
    int          idle_cycles;

    depth_pixel_backprojection u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_frame_start (i_frame_start),
        .i_depth       (i_depth),
        .i_in_red      (i_in_red),
        .i_in_green    (i_in_green),
        .i_in_blue     (i_in_blue),
        .i_area_slot   (i_area_slot),
        .i_area_left   (i_area_left),
        .i_area_top    (i_area_top),
        .i_area_width  (i_area_width),
        .i_area_height (i_area_height),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_point_x     (o_point_x),
        .o_point_y     (o_point_y),
        .o_point_z     (o_point_z),
        .o_out_red     (o_out_red),
        .o_out_green   (o_out_green),
        .o_out_blue    (o_out_blue)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [23:0] project_axis(input int unsigned pos, input int unsigned center,
                                                 input int unsigned depth,
                                                 input int unsigned recip);
        longint signed   offset;
        longint unsigned mag;
        longint unsigned dep;
        longint unsigned rec;
        longint unsigned q;
        offset = longint'(pos << 4) - longint'(center);
        mag = (offset < 0) ? -offset : offset;
        dep = depth;
        rec = recip;
        q = (mag * dep * rec + (64'd1 << 27)) >> 28;
        if (offset < 0) begin
            if (q > AXIS_NEG_MAX) q = AXIS_NEG_MAX;
            q = 64'd0 - q;
        end else if (q > AXIS_POS_MAX) begin
            q = AXIS_POS_MAX;
        end
        return q[23:0];
    endfunction

    function automatic bit backproject_pixel(input t_scan_item it, output t_point pt);
        int unsigned col;
        int unsigned row;
        int unsigned fw;
        bit          hidden;
        bit          produced;
        int          i;
        pt = '0;
        produced = 1'b0;
        if (it.operation == OP_AREA_WRITE) begin
            if (it.slot < MAX_AREAS_DEF) begin
                mask_left[it.slot]   = it.left;
                mask_top[it.slot]    = it.top;
                mask_width[it.slot]  = it.width;
                mask_height[it.slot] = it.height;
                mask_live[it.slot]   = 1'b1;
            end
        end else if (it.operation == OP_AREA_CLEAR) begin
            for (i = 0; i < MAX_AREAS_DEF; i++) mask_live[i] = 1'b0;
        end else if (it.operation == OP_PIXEL) begin
            if (it.frame_start) begin
                scan_col = 0;
                scan_row = 0;
            end
            col = scan_col;
            row = scan_row;
            hidden = 1'b0;
            for (i = 0; i < MAX_AREAS_DEF; i++) begin
                if (mask_live[i] && col >= mask_left[i] && col < mask_left[i] + mask_width[i] &&
                    row >= mask_top[i] && row < mask_top[i] + mask_height[i])
                    hidden = 1'b1;
            end
            if (!hidden && it.depth >= DEPTH_MIN && it.depth <= DEPTH_MAX) begin
                pt.x     = project_axis(col, cfg_center_x, it.depth, cfg_recip_x);
                pt.y     = project_axis(row, cfg_center_y, it.depth, cfg_recip_y);
                pt.z     = it.depth;
                pt.red   = it.red;
                pt.green = it.green;
                pt.blue  = it.blue;
                produced = 1'b1;
            end
            fw = cfg_frame_width;
            if (fw == 0 || fw > FRAME_WIDTH_MAX) fw = FRAME_WIDTH_MAX;
            if (col + 1 >= fw) begin
                scan_col = 0;
                scan_row = (row + 1) & 12'hFFF;
            end else begin
                scan_col = col + 1;
            end
        end
        return produced;
    endfunction

    function automatic t_scan_item random_item();
        t_scan_item it;
        it.operation   = 2'($urandom_range(0, 3));
        it.frame_start = 1'($urandom_range(0, 1));
        it.depth       = 16'($urandom_range(0, 65535));
        it.red         = 8'($urandom_range(0, 255));
        it.green       = 8'($urandom_range(0, 255));
        it.blue        = 8'($urandom_range(0, 255));
        it.slot        = 3'($urandom_range(0, 7));
        it.left        = 12'($urandom_range(0, 4095));
        it.top         = 12'($urandom_range(0, 4095));
        it.width       = 13'($urandom_range(0, 8191));
        it.height      = 13'($urandom_range(0, 8191));
        return it;
    endfunction

    function automatic logic [15:0] pick_depth();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 16'($urandom_range(0, DEPTH_MIN - 1));
        if (r < 13) return 16'($urandom_range(DEPTH_MAX + 1, 65535));
        if (r < 18) begin
            case ($urandom_range(0, 3))
                0: return 16'(DEPTH_MIN);
                1: return 16'(DEPTH_MAX);
                2: return 16'(DEPTH_MIN - 1);
                default: return 16'(DEPTH_MAX + 1);
            endcase
        end
        return 16'($urandom_range(DEPTH_MIN, DEPTH_MAX));
    endfunction

    task automatic enqueue_item(input t_scan_item it);
        pending_items = {pending_items, it};
    endtask

    task automatic push_pixel(input logic fs, input logic [15:0] depth);
        t_scan_item it;
        it = random_item();
        it.operation   = OP_PIXEL;
        it.frame_start = fs;
        it.depth       = depth;
        enqueue_item(it);
    endtask

    task automatic push_area(input int slot, input int left, input int top,
                             input int width, input int height);
        t_scan_item it;
        it = random_item();
        it.operation = OP_AREA_WRITE;
        it.slot      = 3'(slot);
        it.left      = 12'(left);
        it.top       = 12'(top);
        it.width     = 13'(width);
        it.height    = 13'(height);
        enqueue_item(it);
    endtask

    task automatic push_op(input logic [1:0] op);
        t_scan_item it;
        it = random_item();
        it.operation   = op;
        it.frame_start = 1'b1;
        enqueue_item(it);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_CENTER_X:      cfg_center_x    = data[15:0];
            CFG_CENTER_Y:      cfg_center_y    = data[15:0];
            CFG_RECIP_FOCAL_X: cfg_recip_x     = data[23:0];
            CFG_RECIP_FOCAL_Y: cfg_recip_y     = data[23:0];
            CFG_FRAME_WIDTH:   cfg_frame_width = data[12:0];
            default: ;
        endcase
    endtask

    task automatic setup_camera(input int cx, input int cy, input int rfx, input int rfy,
                                input int fw);
        write_register(CFG_CENTER_X, {8'($urandom_range(0, 255)), 16'(cx)});
        write_register(CFG_CENTER_Y, {8'($urandom_range(0, 255)), 16'(cy)});
        write_register(CFG_RECIP_FOCAL_X, 24'(rfx));
        write_register(CFG_RECIP_FOCAL_Y, 24'(rfy));
        write_register(CFG_FRAME_WIDTH, {11'($urandom_range(0, 2047)), 13'(fw)});
    endtask

    task automatic drain();
        @(negedge i_clk);
        while (pending_items.size() != 0 || i_in_valid || expected_points.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // driver: bursts with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                if (backproject_pixel(cur_item, next_point))
                    expected_points = {expected_points, next_point};
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left != 0) begin
                    gap_left = gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    cur_item = pending_items.pop_front();
                    i_operation   <= cur_item.operation;
                    i_frame_start <= cur_item.frame_start;
                    i_depth       <= cur_item.depth;
                    i_in_red      <= cur_item.red;
                    i_in_green    <= cur_item.green;
                    i_in_blue     <= cur_item.blue;
                    i_area_slot   <= cur_item.slot;
                    i_area_left   <= cur_item.left;
                    i_area_top    <= cur_item.top;
                    i_area_width  <= cur_item.width;
                    i_area_height <= cur_item.height;
                    i_in_valid    <= 1'b1;
                    if (burst_left != 0) begin
                        burst_left = burst_left - 1;
                    end else begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 160)
                                                                 : $urandom_range(0, 10);
                        gap_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 24)
                                                               : $urandom_range(0, 4);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor, output stall pattern and watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  = 0;
            stall_mode  = STALL_NONE;
            idle_cycles = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_points.size() == 0) begin
                    $error("point with nothing expected: point_x %0d point_y %0d point_z %0d",
                           o_point_x, o_point_y, o_point_z);
                    mismatches++;
                end else begin
                    want = expected_points.pop_front();
                    if (o_point_x !== want.x) begin
                        $error("point_x expected %0d actual %0d", want.x, o_point_x);
                        mismatches++;
                    end
                    if (o_point_y !== want.y) begin
                        $error("point_y expected %0d actual %0d", want.y, o_point_y);
                        mismatches++;
                    end
                    if (o_point_z !== want.z) begin
                        $error("point_z expected %0d actual %0d", want.z, o_point_z);
                        mismatches++;
                    end
                    if (o_out_red !== want.red) begin
                        $error("out_red expected %0d actual %0d", want.red, o_out_red);
                        mismatches++;
                    end
                    if (o_out_green !== want.green) begin
                        $error("out_green expected %0d actual %0d", want.green, o_out_green);
                        mismatches++;
                    end
                    if (o_out_blue !== want.blue) begin
                        $error("out_blue expected %0d actual %0d", want.blue, o_out_blue);
                        mismatches++;
                    end
                end
            end

            if (stall_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                stall_left = $urandom_range(20, 150);
            end else begin
                stall_left = stall_left - 1;
            end
            case (stall_mode)
                STALL_NONE:   i_out_stall <= 1'b0;
                STALL_RANDOM: i_out_stall <= ($urandom_range(0, 1) == 1);
                STALL_LONG:   i_out_stall <= ((stall_left % 16) < 12);
                default:      i_out_stall <= ($urandom_range(0, 7) != 0);
            endcase

            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles = idle_cycles + 1;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("Testbench completed WITH ERRORS");
                    $finish;
                end
            end
        end
    end

    initial begin
        t_scan_item it;
        int         phase;
        int         n;
        int         r;
        int         fw;
        int         fw_eff;
        int         cx;
        int         cy;
        int         rfx;
        int         rfy;
        int         i;

        mismatches      = 0;
        scan_col        = 0;
        scan_row        = 0;
        cfg_center_x    = 0;
        cfg_center_y    = 0;
        cfg_recip_x     = 0;
        cfg_recip_y     = 0;
        cfg_frame_width = FRAME_WIDTH_RST;
        for (i = 0; i < MAX_AREAS_DEF; i++) begin
            mask_left[i]   = 0;
            mask_top[i]    = 0;
            mask_width[i]  = 0;
            mask_height[i] = 0;
            mask_live[i]   = 1'b0;
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset configuration: zero center and reciprocals
        push_pixel(1'b0, 16'd1024);
        push_pixel(1'b0, 16'd20);
        push_pixel(1'b0, 16'(DEPTH_MAX));
        drain();

        // directed: depth limits, colors, masking, table ops
        setup_camera(5120, 3840, 31957, 31957, 8);
        it = random_item();
        it.operation   = OP_PIXEL;
        it.frame_start = 1'b1;
        it.depth       = 16'd1024;
        it.red         = 8'h00;
        it.green       = 8'h00;
        it.blue        = 8'h00;
        enqueue_item(it);
        it.frame_start = 1'b0;
        it.red         = 8'hFF;
        it.green       = 8'hFF;
        it.blue        = 8'hFF;
        enqueue_item(it);
        push_pixel(1'b0, 16'd0);
        push_pixel(1'b0, 16'(DEPTH_MIN - 1));
        push_pixel(1'b0, 16'(DEPTH_MIN));
        push_pixel(1'b0, 16'(DEPTH_MAX));
        push_pixel(1'b0, 16'(DEPTH_MAX + 1));
        push_pixel(1'b0, 16'hFFFF);
        push_area(0, 2, 1, 3, 1);
        for (i = 0; i < 8; i++) push_pixel(1'b0, 16'd2048);
        push_area(1, 0, 0, 0, 5);
        push_area(7, 0, 0, 8191, 8191);
        push_pixel(1'b0, 16'd2048);
        push_op(OP_AREA_CLEAR);
        push_op(OP_RESERVED);
        push_pixel(1'b0, 16'd2048);
        drain();

        // extremes: negative saturation, spare register indexes
        setup_camera(65535, 0, 24'hFFFFFF, 24'hFFFFFF, FRAME_WIDTH_MAX);
        write_register(CFG_SPARE_LO, 24'($urandom_range(0, 24'hFFFFFF)));
        write_register(CFG_SPARE_HI, 24'hFFFFFF);
        push_pixel(1'b1, 16'(DEPTH_MAX));
        push_pixel(1'b0, 16'(DEPTH_MIN));
        push_pixel(1'b0, 16'd5000);
        drain();

        // zero width acts as full width
        setup_camera(0, 65535, 24'hFFFFFF, 24'd40000, 0);
        push_pixel(1'b1, 16'(DEPTH_MAX));
        for (i = 1; i < 40; i++) push_pixel(1'b0, pick_depth());
        drain();

        // one pixel per row, one row masked
        setup_camera(8, 32768, 30000, 24'hFFFFFF, 1);
        push_area(3, 0, 20, 1, 1);
        push_pixel(1'b1, 16'd3000);
        for (i = 1; i < 40; i++) push_pixel(1'b0, pick_depth());
        push_op(OP_AREA_CLEAR);
        drain();

        // random phases
        for (phase = 0; phase < 8; phase++) begin
            case ($urandom_range(0, 5))
                0: fw = 1;
                1: fw = $urandom_range(2, 16);
                2: fw = FRAME_WIDTH_RST;
                3: fw = FRAME_WIDTH_MAX;
                4: fw = $urandom_range(17, 200);
                default: fw = $urandom_range(0, 8191);
            endcase
            fw_eff = (fw == 0 || fw > FRAME_WIDTH_MAX) ? FRAME_WIDTH_MAX : fw;
            if ($urandom_range(0, 3) != 0) begin
                cx  = $urandom_range(0, 16 * (fw_eff < 64 ? fw_eff : 64));
                cy  = $urandom_range(0, 160);
                rfx = $urandom_range(8000, 120000);
                rfy = $urandom_range(8000, 120000);
            end else begin
                cx  = $urandom_range(0, 65535);
                cy  = $urandom_range(0, 65535);
                rfx = $urandom_range(0, 24'hFFFFFF);
                rfy = $urandom_range(0, 24'hFFFFFF);
            end
            setup_camera(cx, cy, rfx, rfy, fw);
            push_pixel(1'b1, pick_depth());
            for (n = 0; n < 42; n++) begin
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    push_op(OP_RESERVED);
                end else if (r < 10) begin
                    it = random_item();
                    it.operation = OP_AREA_CLEAR;
                    enqueue_item(it);
                end else if (r < 24) begin
                    if ($urandom_range(0, 6) != 0)
                        push_area($urandom_range(0, 7), $urandom_range(0, 15),
                                  $urandom_range(0, 7), $urandom_range(0, 6),
                                  $urandom_range(0, 4));
                    else
                        push_area($urandom_range(0, 7), $urandom_range(0, 4095),
                                  $urandom_range(0, 4095), $urandom_range(0, 8191),
                                  $urandom_range(0, 8191));
                end else begin
                    push_pixel(($urandom_range(0, 29) == 0), pick_depth());
                end
            end
            drain();
        end

        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
